// ----- hdl/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the segment closest-point pipeline
// Holds coordinate formats, payload structs and internal word widths.
// ----------------------------------------------------------------------------
package spc_pkg;

	// Coordinate format: signed Q16.16.
	localparam int CW = 32;
	localparam int FB = 16;

	// Difference vectors, dot products and the wide determinant terms.
	localparam int VW = CW + 1;
	localparam int DW = 2 * VW + 2;
	localparam int WW = 2 * DW;

	// Numerator and denominator width of the two later divisions.
	localparam int TW = DW + FB + 4;

	// Segment parameter, unsigned Q1.16 in [0, 1].
	localparam int QW = FB + 1;
	localparam logic [QW-1:0] ONE_Q = {1'b1, {FB{1'b0}}};

	// Product of a coordinate difference and a segment parameter.
	localparam int PRW = VW + QW + 1;

	// Configuration register file.
	localparam int TH_W    = 40;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 64;
	localparam int REG_BIT = 3;
	localparam logic REG_THRESHOLD = 1'b0;

	// The threshold is kept in units of 2^(-2*FB).
	localparam int THR_SHIFT = 2 * FB;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t a0_x;
		coord_t a0_y;
		coord_t a0_z;
		coord_t a1_x;
		coord_t a1_y;
		coord_t a1_z;
		coord_t b0_x;
		coord_t b0_y;
		coord_t b0_z;
		coord_t b1_x;
		coord_t b1_y;
		coord_t b1_z;
	} seg_t;

	typedef struct packed {
		coord_t near_a_x;
		coord_t near_a_y;
		coord_t near_a_z;
		coord_t near_b_x;
		coord_t near_b_y;
		coord_t near_b_z;
	} near_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
	} vec_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} pnt_t;

	// Geometry that rides along until the final point step.
	typedef struct packed {
		pnt_t p0;
		pnt_t q0;
		vec_t v1;
		vec_t v2;
	} geo_t;

	// The five dot products of one transaction.
	typedef struct packed {
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		logic signed [DW-1:0] c;
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] e;
	} dots_t;

endpackage

// ----- hdl/spc_dly.sv -----
// ----------------------------------------------------------------------------
// spc_dly: side-band delay line
// Carries data alongside the arithmetic stages, one register per stage.
// ----------------------------------------------------------------------------
module spc_dly #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] dl_s [N];

	// First tap loads the incoming word.
	always_ff @(posedge clk) begin
		if (en) begin
			dl_s[0] <= d;
		end
	end

	// Remaining taps shift in lock step with the pipeline.
	for (genvar i = 1; i < N; i++) begin : g_tap
		always_ff @(posedge clk) begin
			if (en) begin
				dl_s[i] <= dl_s[i-1];
			end
		end
	end

	assign q = dl_s[N-1];

endmodule

// ----- hdl/spc_dot.sv -----
// ----------------------------------------------------------------------------
// spc_dot: three-term dot product
// Stage one forms the three products, stage two adds them.
// ----------------------------------------------------------------------------
module spc_dot (
	input  logic                         clk,
	input  logic                         en,
	input  spc_pkg::vec_t                u,
	input  spc_pkg::vec_t                v,
	output logic signed [spc_pkg::DW-1:0] dot
);
	import spc_pkg::*;

	logic signed [2*VW-1:0] px_s1;
	logic signed [2*VW-1:0] py_s1;
	logic signed [2*VW-1:0] pz_s1;

	// Per-axis products.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= u.x * v.x;
			py_s1 <= u.y * v.y;
			pz_s1 <= u.z * v.z;
		end
	end

	// Sum of the three products, sign extended.
	always_ff @(posedge clk) begin
		if (en) begin
			dot <= DW'(px_s1) + DW'(py_s1) + DW'(pz_s1);
		end
	end

endmodule

// ----- hdl/spc_mul.sv -----
// ----------------------------------------------------------------------------
// spc_mul: two-stage signed multiplier
// Splits both operands into halves; partial products are registered and then
// summed with their weights in the second stage.
// ----------------------------------------------------------------------------
module spc_mul #(
	parameter int AW = 68,
	parameter int BW = 68
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [AW-1:0]   a,
	input  logic signed [BW-1:0]   b,
	output logic signed [AW+BW-1:0] p
);
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic signed [AH-1:0] ah;
	logic signed [AL:0]   al;
	logic signed [BH-1:0] bh;
	logic signed [BL:0]   bl;

	logic signed [AH+BH-1:0]   hh_s1;
	logic signed [AH+BL:0]     hl_s1;
	logic signed [AL+BH:0]     lh_s1;
	logic signed [AL+BL+1:0]   ll_s1;

	// Upper halves keep the sign, lower halves are zero extended.
	assign ah = a[AW-1:AL];
	assign al = $signed({1'b0, a[AL-1:0]});
	assign bh = b[BW-1:BL];
	assign bl = $signed({1'b0, b[BL-1:0]});

	// Partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= ah * bh;
			hl_s1 <= ah * bl;
			lh_s1 <= al * bh;
			ll_s1 <= al * bl;
		end
	end

	// Weighted sum.
	always_ff @(posedge clk) begin
		if (en) begin
			p <= (PW'(hh_s1) <<< (AL + BL)) + (PW'(hl_s1) <<< AL)
				+ (PW'(lh_s1) <<< BL) + PW'(ll_s1);
		end
	end

endmodule

// ----- hdl/spc_div.sv -----
// ----------------------------------------------------------------------------
// spc_div: pipelined fractional divider
// Returns num/den as an unsigned Q1.FB fraction clamped to [0, 1], truncated.
// A zero denominator or a non-positive quotient gives 0. One sign-fix stage,
// one classify stage and one restoring step per fraction bit.
// ----------------------------------------------------------------------------
module spc_div #(
	parameter int W = 136
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [W-1:0]         num,
	input  logic signed [W-1:0]         den,
	output logic [spc_pkg::QW-1:0]      q
);
	import spc_pkg::*;

	logic signed [W-1:0] num_s1;
	logic signed [W-1:0] den_s1;

	logic [W-2:0]  rem_s  [FB+1];
	logic [W-2:0]  dv_s   [FB+1];
	logic [FB-1:0] qb_s   [FB+1];
	logic          zero_s [FB+1];
	logic          one_s  [FB+1];

	// Make the denominator non-negative.
	always_ff @(posedge clk) begin
		if (en) begin
			if (den[W-1]) begin
				num_s1 <= -num;
				den_s1 <= -den;
			end else begin
				num_s1 <= num;
				den_s1 <= den;
			end
		end
	end

	// Classify: zero result, full result, or a proper fraction.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (den_s1 == '0) || num_s1[W-1] || (num_s1 == '0);
			one_s[0]  <= num_s1[W-2:0] >= den_s1[W-2:0];
			rem_s[0]  <= num_s1[W-2:0];
			dv_s[0]   <= den_s1[W-2:0];
			qb_s[0]   <= '0;
		end
	end

	// One quotient bit per stage.
	for (genvar i = 0; i < FB; i++) begin : g_step
		logic [W-1:0] rem2;
		logic [W-1:0] diff;
		logic         ge;

		assign rem2 = {rem_s[i], 1'b0};
		assign diff = rem2 - {1'b0, dv_s[i]};
		assign ge   = rem2 >= {1'b0, dv_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[W-2:0] : rem2[W-2:0];
				qb_s[i+1]   <= {qb_s[i][FB-2:0], ge};
				dv_s[i+1]   <= dv_s[i];
				zero_s[i+1] <= zero_s[i];
				one_s[i+1]  <= one_s[i];
			end
		end
	end

	// Apply the clamps.
	always_comb begin
		priority if (zero_s[FB]) begin
			q = '0;
		end else if (one_s[FB]) begin
			q = ONE_Q;
		end else begin
			q = {1'b0, qb_s[FB]};
		end
	end

endmodule

// ----- hdl/segment_pair_closest_points.sv -----
// ----------------------------------------------------------------------------
// segment_pair_closest_points: closest points between two 3D segments
// Pipelined fixed-point solver for the closest point on each of two segments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel seg_valid/seg_stall/seg carries one segment pair per
//   transaction (Q16.16 endpoints). Output channel near_valid/near_stall/near
//   returns the closest point on each segment, one transaction per input.
//   The APB port holds parallel_threshold at byte address 0; write it only
//   while no transaction is in flight.
// Throughput and depth:
//   One transaction per cycle while the output does not stall. The depth
//   is set by the three fractional dividers in series (one quotient bit
//   per stage) and the multiplier stages between them.
// Reset:
//   arst_n clears the pipeline valid bits, the skid buffer and the threshold.
// Stall:
//   A stalled result is parked in a one-entry skid buffer while the pipeline
//   moves on once more; the pipeline then holds and seg_stall is raised until
//   the skid buffer drains.
// ----------------------------------------------------------------------------
module segment_pair_closest_points (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spc_pkg::APB_AW-1:0]    paddr,
	input  logic [spc_pkg::APB_DW-1:0]    pwdata,
	output logic [spc_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	input  logic                          seg_valid,
	output logic                          seg_stall,
	input  spc_pkg::seg_t                 seg,
	output logic                          near_valid,
	input  logic                          near_stall,
	output spc_pkg::near_t                near
);
	import spc_pkg::*;

	// Stage numbers of the pipeline.
	localparam int DIV_N   = FB + 2;
	localparam int S_SUB   = 1;
	localparam int S_DOT   = S_SUB + 2;
	localparam int S_WMUL  = S_DOT + 2;
	localparam int S_DET   = S_WMUL + 1;
	localparam int S_MAG   = S_DET + 1;
	localparam int S_SOL   = S_MAG + 1;
	localparam int S_DIVS  = S_SOL + DIV_N;
	localparam int S_SB    = S_DIVS + 2;
	localparam int S_NT    = S_SB + 1;
	localparam int S_DIVT  = S_NT + DIV_N;
	localparam int S_TB    = S_DIVT + 2;
	localparam int S_NS    = S_TB + 1;
	localparam int S_DIVS2 = S_NS + DIV_N;
	localparam int S_PRD   = S_DIVS2 + 1;
	localparam int S_OUT   = S_PRD + 1;

	localparam int SBW = QW + 1 + DW;

	logic              adv;
	logic [S_OUT:1]    vld;
	logic              skid_full_q;
	near_t             skid_q;
	logic [TH_W-1:0]   thr_q;

	geo_t                   geo_s1;
	vec_t                   r_s1;
	geo_t                   geo_s68;
	logic signed [DW-1:0]   a_s3, b_s3, c_s3, d_s3, e_s3;
	dots_t                  dots_s3, dots_s26, dots_s28, dots_s47, dots_s49;
	logic signed [WW-1:0]   bb_s5, ac_s5, cd_s5, be_s5;
	logic signed [WW-1:0]   det_s6, num_s6, det_s7, num_s7, mag_s7, det_s8, num_s8;
	logic [WW-1:0]          lim;
	logic [QW-1:0]          s_s26, t_s47, t_s68, s2_s68;
	logic signed [QW:0]     s_ext, t_ext;
	logic signed [SBW-1:0]  sb_s28, tb_s49;
	logic signed [TW-1:0]   numt_s29, dent_s29, nums_s50, dens_s50;
	logic signed [PRW-1:0]  pa_s69 [3];
	logic signed [PRW-1:0]  pb_s69 [3];
	pnt_t                   p0_s69, q0_s69;
	near_t                  out_s70;

	// Configuration port: one threshold register, always ready.
	assign pready = 1'b1;
	assign prdata = (paddr[REG_BIT] == REG_THRESHOLD) ? APB_DW'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && (paddr[REG_BIT] == REG_THRESHOLD)) begin
			thr_q <= pwdata[TH_W-1:0];
		end
	end

	// Pipeline control: the whole pipeline moves unless the skid is occupied.
	assign adv       = !skid_full_q;
	assign seg_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[S_OUT-1:1], seg_valid};
		end
	end

	// Skid buffer between the last stage and the output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (!skid_full_q) begin
			skid_full_q <= vld[S_OUT] && near_stall;
		end else begin
			skid_full_q <= near_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_q <= out_s70;
		end
	end

	assign near_valid = skid_full_q || vld[S_OUT];
	assign near       = skid_full_q ? skid_q : out_s70;

	// Direction vectors and the offset between the start points.
	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1.p0.x <= seg.a0_x;
			geo_s1.p0.y <= seg.a0_y;
			geo_s1.p0.z <= seg.a0_z;
			geo_s1.q0.x <= seg.b0_x;
			geo_s1.q0.y <= seg.b0_y;
			geo_s1.q0.z <= seg.b0_z;
			geo_s1.v1.x <= VW'(seg.a1_x) - VW'(seg.a0_x);
			geo_s1.v1.y <= VW'(seg.a1_y) - VW'(seg.a0_y);
			geo_s1.v1.z <= VW'(seg.a1_z) - VW'(seg.a0_z);
			geo_s1.v2.x <= VW'(seg.b1_x) - VW'(seg.b0_x);
			geo_s1.v2.y <= VW'(seg.b1_y) - VW'(seg.b0_y);
			geo_s1.v2.z <= VW'(seg.b1_z) - VW'(seg.b0_z);
			r_s1.x      <= VW'(seg.a0_x) - VW'(seg.b0_x);
			r_s1.y      <= VW'(seg.a0_y) - VW'(seg.b0_y);
			r_s1.z      <= VW'(seg.a0_z) - VW'(seg.b0_z);
		end
	end

	spc_dly #(.W($bits(geo_t)), .N(S_DIVS2 - S_SUB)) u_dly_geo (
		.clk(clk), .en(adv), .d(geo_s1), .q(geo_s68)
	);

	// The five dot products.
	spc_dot u_dot_a (.clk(clk), .en(adv), .u(geo_s1.v1), .v(geo_s1.v1), .dot(a_s3));
	spc_dot u_dot_b (.clk(clk), .en(adv), .u(geo_s1.v1), .v(geo_s1.v2), .dot(b_s3));
	spc_dot u_dot_c (.clk(clk), .en(adv), .u(geo_s1.v2), .v(geo_s1.v2), .dot(c_s3));
	spc_dot u_dot_d (.clk(clk), .en(adv), .u(geo_s1.v1), .v(r_s1), .dot(d_s3));
	spc_dot u_dot_e (.clk(clk), .en(adv), .u(geo_s1.v2), .v(r_s1), .dot(e_s3));

	assign dots_s3 = '{a: a_s3, b: b_s3, c: c_s3, d: d_s3, e: e_s3};

	spc_dly #(.W($bits(dots_t)), .N(S_DIVS - S_DOT)) u_dly_dots0 (
		.clk(clk), .en(adv), .d(dots_s3), .q(dots_s26)
	);
	spc_dly #(.W($bits(dots_t)), .N(S_SB - S_DIVS)) u_dly_dots1 (
		.clk(clk), .en(adv), .d(dots_s26), .q(dots_s28)
	);
	spc_dly #(.W($bits(dots_t)), .N(S_DIVT - S_SB)) u_dly_dots2 (
		.clk(clk), .en(adv), .d(dots_s28), .q(dots_s47)
	);
	spc_dly #(.W($bits(dots_t)), .N(S_TB - S_DIVT)) u_dly_dots3 (
		.clk(clk), .en(adv), .d(dots_s47), .q(dots_s49)
	);

	// Wide products for the determinant and the first numerator.
	spc_mul #(.AW(DW), .BW(DW)) u_mul_bb (.clk(clk), .en(adv), .a(b_s3), .b(b_s3), .p(bb_s5));
	spc_mul #(.AW(DW), .BW(DW)) u_mul_ac (.clk(clk), .en(adv), .a(a_s3), .b(c_s3), .p(ac_s5));
	spc_mul #(.AW(DW), .BW(DW)) u_mul_cd (.clk(clk), .en(adv), .a(c_s3), .b(d_s3), .p(cd_s5));
	spc_mul #(.AW(DW), .BW(DW)) u_mul_be (.clk(clk), .en(adv), .a(b_s3), .b(e_s3), .p(be_s5));

	// Determinant, its magnitude, and the near-parallel test.
	assign lim = WW'(thr_q) << THR_SHIFT;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s6 <= bb_s5 - ac_s5;
			num_s6 <= cd_s5 - be_s5;
			det_s7 <= det_s6;
			num_s7 <= num_s6;
			mag_s7 <= det_s6[WW-1] ? -det_s6 : det_s6;
			det_s8 <= det_s7;
			num_s8 <= (mag_s7 > lim) ? num_s7 : '0;
		end
	end

	// First solve for s.
	spc_div #(.W(WW)) u_div_s (.clk(clk), .en(adv), .num(num_s8), .den(det_s8), .q(s_s26));

	assign s_ext = $signed({1'b0, s_s26});

	spc_mul #(.AW(QW + 1), .BW(DW)) u_mul_sb (
		.clk(clk), .en(adv), .a(s_ext), .b(dots_s26.b), .p(sb_s28)
	);

	// t = (e + s*b) / c.
	always_ff @(posedge clk) begin
		if (adv) begin
			numt_s29 <= (TW'(dots_s28.e) <<< FB) + TW'(sb_s28);
			dent_s29 <= TW'(dots_s28.c) <<< FB;
		end
	end

	spc_div #(.W(TW)) u_div_t (.clk(clk), .en(adv), .num(numt_s29), .den(dent_s29), .q(t_s47));

	spc_dly #(.W(QW), .N(S_DIVS2 - S_DIVT)) u_dly_t (
		.clk(clk), .en(adv), .d(t_s47), .q(t_s68)
	);

	assign t_ext = $signed({1'b0, t_s47});

	spc_mul #(.AW(QW + 1), .BW(DW)) u_mul_tb (
		.clk(clk), .en(adv), .a(t_ext), .b(dots_s47.b), .p(tb_s49)
	);

	// s = (t*b - d) / a.
	always_ff @(posedge clk) begin
		if (adv) begin
			nums_s50 <= TW'(tb_s49) - (TW'(dots_s49.d) <<< FB);
			dens_s50 <= TW'(dots_s49.a) <<< FB;
		end
	end

	spc_div #(.W(TW)) u_div_s2 (.clk(clk), .en(adv), .num(nums_s50), .den(dens_s50), .q(s2_s68));

	// Scale the direction vectors by the final parameters.
	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s69[0] <= geo_s68.v1.x * $signed({1'b0, s2_s68});
			pa_s69[1] <= geo_s68.v1.y * $signed({1'b0, s2_s68});
			pa_s69[2] <= geo_s68.v1.z * $signed({1'b0, s2_s68});
			pb_s69[0] <= geo_s68.v2.x * $signed({1'b0, t_s68});
			pb_s69[1] <= geo_s68.v2.y * $signed({1'b0, t_s68});
			pb_s69[2] <= geo_s68.v2.z * $signed({1'b0, t_s68});
			p0_s69    <= geo_s68.p0;
			q0_s69    <= geo_s68.q0;
		end
	end

	// Closest points: start point plus the floored scaled vector.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_s70.near_a_x <= p0_s69.x + CW'(pa_s69[0] >>> FB);
			out_s70.near_a_y <= p0_s69.y + CW'(pa_s69[1] >>> FB);
			out_s70.near_a_z <= p0_s69.z + CW'(pa_s69[2] >>> FB);
			out_s70.near_b_x <= q0_s69.x + CW'(pb_s69[0] >>> FB);
			out_s70.near_b_y <= q0_s69.y + CW'(pb_s69[1] >>> FB);
			out_s70.near_b_z <= q0_s69.z + CW'(pb_s69[2] >>> FB);
		end
	end

`ifndef NO_ASSERTIONS
	// The clamped t never exceeds one.
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld[S_DIVT] |-> (t_s47 <= ONE_Q))
		else $error("t parameter out of range");

	// The final s never exceeds one.
	a_s_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld[S_DIVS2] |-> (s2_s68 <= ONE_Q))
		else $error("s parameter out of range");

	// A parked result stays parked and unchanged while the receiver stalls.
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && near_stall) |=> (skid_full_q && $stable(skid_q)))
		else $error("skid buffer lost a stalled transaction");
`endif

endmodule
